// ===== rtl/swrd_pkg.sv =====
// shared types, constants and the tree merge function for the window range detector
package swrd_pkg;

    // default sizes handed to the top level parameters
    localparam int WINDOW_MAX_DEF    = 64;
    localparam int POSITION_BITS_DEF = 20;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int LIMIT_W     = 32;
    localparam int LEN_CFG_W   = 7;
    localparam int POS_FIELD_W = 20;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LEN  = 2'd0,
        CFG_RANGE_LIMIT = 2'd1
    } cfg_index_t;

    // partial max / min over a run of window taps
    typedef struct packed {
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] lo;
        logic                     vld;
    } node_t;

    // per-request side information carried down the tree pipeline
    typedef struct packed {
        logic                   full;
        logic [POS_FIELD_W-1:0] pos_first;
        logic [POS_FIELD_W-1:0] pos_last;
    } sb_t;

    // merge two neighboring runs; the lower run is valid whenever the upper one is
    function automatic node_t node_merge(input node_t a, input node_t b);
        node_t r;
        r = a;
        if (b.vld)
        begin
            r.hi  = (b.hi > a.hi) ? b.hi : a.hi;
            r.lo  = (b.lo < a.lo) ? b.lo : a.lo;
            r.vld = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/sliding_window_range_detector.sv =====
// top level: config registers, pipelined max/min tree and result register
//
// Usage
//   Samples enter on the sample channel (sample_valid / sample_stall) together
//   with first_of_set, which restarts the window and the position count.
//   Each request yields exactly one result on the result channel
//   (result_valid / result_stall): window_full, in_range, first_pos, last_pos.
//   window_len and range_limit are written through the cfg channel, index 0
//   and 1; cfg_ready is always high. Write them only while the block is idle.
// Throughput and pipeline
//   One request per cycle while sample_stall is low. Each max/min tree
//   level is registered, and the last level feeds the compare in the
//   result register.
// Reset and stall
//   Reset empties the pipeline, clears the position count and loads
//   window_len = 1, range_limit = 0. A stalled result holds; stages behind it
//   keep filling bubbles, and sample_stall rises only when every stage is full.
module sliding_window_range_detector
    import swrd_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [LIMIT_W-1:0]       cfg_data,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     first_of_set,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     window_full,
    output logic                     in_range,
    output logic [POS_FIELD_W-1:0]   first_pos,
    output logic [POS_FIELD_W-1:0]   last_pos
);

    localparam int LEVELS = $clog2(WINDOW_MAX);
    localparam int LEAF_N = 2 ** LEVELS;

    logic [LEN_CFG_W-1:0]   window_len_reg;
    logic [LIMIT_W-1:0]     range_limit_reg;
    logic [LEVELS:0]        vld_reg;
    logic [LEVELS:0]        rdy;
    logic                   accept;
    node_t                  leaf [LEAF_N];
    node_t                  node_reg [1:LEAF_N-1];
    sb_t                    front_sb;
    sb_t                    sb_reg [LEVELS];
    logic [DATA_W:0]        spread;
    logic                   window_full_reg;
    logic                   in_range_reg;
    logic [POS_FIELD_W-1:0] first_pos_reg;
    logic [POS_FIELD_W-1:0] last_pos_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg  <= LEN_CFG_W'(1);
            range_limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LEN:  window_len_reg  <= cfg_data[LEN_CFG_W-1:0];
                CFG_RANGE_LIMIT: range_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // stage ready chain, output stage last
    assign rdy[LEVELS] = !vld_reg[LEVELS] || !result_stall;
    for (genvar s = 0; s < LEVELS; s++)
    begin : g_rdy
        assign rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    assign sample_stall = !rdy[0];
    assign accept       = sample_valid && rdy[0];

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= sample_valid;
            for (int s = 1; s <= LEVELS; s++)
            begin
                if (rdy[s])
                    vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // shift chain, position count and leaves
    swrd_front #(
        .WINDOW_MAX    (WINDOW_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .sample       (sample),
        .first_of_set (first_of_set),
        .window_len   (window_len_reg),
        .leaf         (leaf),
        .sb           (front_sb)
    );

    // registered max/min tree, heap layout, root at node 1
    for (genvar j = 1; j < LEAF_N; j++)
    begin : g_node
        localparam int D = $clog2(j + 1) - 1;
        localparam int S = LEVELS - 1 - D;
        node_t ca;
        node_t cb;

        if (2 * j >= LEAF_N)
        begin : g_from_leaf
            assign ca = leaf[2*j-LEAF_N];
            assign cb = leaf[2*j+1-LEAF_N];
        end
        else
        begin : g_from_node
            assign ca = node_reg[2*j];
            assign cb = node_reg[2*j+1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[S])
                node_reg[j] <= node_merge(ca, cb);
        end
    end

    // side information travels with the tree
    always_ff @(posedge clk)
    begin
        if (rdy[0])
            sb_reg[0] <= front_sb;
        for (int s = 1; s < LEVELS; s++)
        begin
            if (rdy[s])
                sb_reg[s] <= sb_reg[s-1];
        end
    end

    // spread at 33 bits, never negative
    assign spread = {node_reg[1].hi[DATA_W-1], node_reg[1].hi}
                  - {node_reg[1].lo[DATA_W-1], node_reg[1].lo};

    // result register
    always_ff @(posedge clk)
    begin
        if (rdy[LEVELS])
        begin
            window_full_reg <= sb_reg[LEVELS-1].full;
            in_range_reg    <= sb_reg[LEVELS-1].full
                               && (spread <= {1'b0, range_limit_reg});
            first_pos_reg   <= sb_reg[LEVELS-1].pos_first;
            last_pos_reg    <= sb_reg[LEVELS-1].pos_last;
        end
    end

    assign result_valid = vld_reg[LEVELS];
    assign window_full  = window_full_reg;
    assign in_range     = in_range_reg;
    assign first_pos    = first_pos_reg;
    assign last_pos     = last_pos_reg;

    // checks

    // a partial window never passes and starts at position one
    a_not_full_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !window_full |-> !in_range)
        else $error("in_range set on a window that is not full");

    a_not_full_first: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !window_full |-> first_pos == POS_FIELD_W'(1))
        else $error("first_pos not one on a window that is not full");

    // the root always covers at least the newest sample
    a_root_valid: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LEVELS-1] |-> node_reg[1].vld)
        else $error("tree root empty for a live request");

    a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LEVELS-1] |-> node_reg[1].hi >= node_reg[1].lo)
        else $error("tree root maximum below minimum");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample channel stalled while the result side can move");

endmodule

// ===== rtl/swrd_front.sv =====
// sample shift chain, position counter and tree leaf formation
module swrd_front
    import swrd_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int LEAF_N       = 2 ** $clog2(WINDOW_MAX)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     first_of_set,
    input  logic [LEN_CFG_W-1:0]     window_len,
    output node_t                    leaf [LEAF_N],
    output sb_t                      sb
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CLEN_W = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam int PW     = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
    localparam int FW     = (PW > POS_FIELD_W) ? PW : POS_FIELD_W;

    logic signed [DATA_W-1:0]  chain_reg [WINDOW_MAX-1];
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_base;
    logic [POSITION_BITS-1:0]  pos_next;
    logic [LEN_W-1:0]          len_eff;
    logic [PW-1:0]             pos_w;
    logic [PW-1:0]             len_w;
    logic [PW-1:0]             first_w;
    logic [FW-1:0]             first_f;
    logic [FW-1:0]             last_f;
    logic                      full;

    // window length clamped to 1 .. WINDOW_MAX
    always_comb
    begin
        if (window_len == '0)
            len_eff = LEN_W'(1);
        else if (CLEN_W'(window_len) > CLEN_W'(WINDOW_MAX))
            len_eff = LEN_W'(WINDOW_MAX);
        else
            len_eff = LEN_W'(window_len);
    end

    // saturating position count, restarted by first_of_set
    assign pos_base = first_of_set ? '0 : pos_reg;
    assign pos_next = (pos_base != '1) ? pos_base + POSITION_BITS'(1) : pos_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (accept)
            pos_reg <= pos_next;
    end

    // shift chain of older samples, newest at tap 0, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_MAX - 1; i++)
                chain_reg[i] <= '0;
        end
        else if (accept)
        begin
            chain_reg[0] <= sample;
            for (int i = 1; i < WINDOW_MAX - 1; i++)
                chain_reg[i] <= chain_reg[i-1];
        end
    end

    // fullness and window positions
    assign pos_w   = PW'(pos_next);
    assign len_w   = PW'(len_eff);
    assign full    = (pos_w >= len_w);
    assign first_w = pos_w - len_w + PW'(1);
    assign first_f = FW'(first_w);
    assign last_f  = FW'(pos_next);

    assign sb.full      = full;
    assign sb.pos_first = full ? first_f[POS_FIELD_W-1:0] : POS_FIELD_W'(1);
    assign sb.pos_last  = last_f[POS_FIELD_W-1:0];

    // leaves: new sample plus the held taps, masked by window length
    for (genvar i = 0; i < LEAF_N; i++)
    begin : g_leaf
        if (i == 0)
        begin : g_new
            assign leaf[i] = '{hi: sample, lo: sample, vld: 1'b1};
        end
        else if (i < WINDOW_MAX)
        begin : g_tap
            assign leaf[i] = '{hi: chain_reg[i-1], lo: chain_reg[i-1],
                               vld: (LEN_W'(i) < len_eff)};
        end
        else
        begin : g_pad
            assign leaf[i] = '{hi: '0, lo: '0, vld: 1'b0};
        end
    end

endmodule

// ===== tb/tb_sliding_window_range_detector.sv =====
// testbench for the sliding window range detector: directed and random streams against a predictor
`timescale 1ns / 100ps

module tb_sliding_window_range_detector;
    import swrd_pkg::*;

    localparam int RING_DEPTH     = WINDOW_MAX_DEF;
    localparam int unsigned POS_TOP = (32'd1 << POSITION_BITS_DEF) - 1;
    localparam int IDLE_PERCENT   = 21;
    localparam int STUCK_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 20;

    // one predicted result
    typedef struct packed {
        logic                   full;
        logic                   ok;
        logic [POS_FIELD_W-1:0] pos_first;
        logic [POS_FIELD_W-1:0] pos_last;
    } window_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [LIMIT_W-1:0]       cfg_data;
    logic                     sample_valid;
    logic                     sample_stall;
    logic signed [DATA_W-1:0] sample;
    logic                     first_of_set;
    logic                     result_valid;
    logic                     result_stall;
    logic                     window_full;
    logic                     in_range;
    logic [POS_FIELD_W-1:0]   first_pos;
    logic [POS_FIELD_W-1:0]   last_pos;

    // predictor state and register copies
    logic signed [DATA_W-1:0] window_ring [RING_DEPTH];
    int unsigned              ring_head;
    int unsigned              seen_count;
    logic [LEN_CFG_W-1:0]     len_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    window_result_t pending_results [$];
    window_result_t want;
    int             error_count;
    int             result_index;
    int             stuck_cycles;
    bit             quiet_mode;

    sliding_window_range_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .first_of_set (first_of_set),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .window_full  (window_full),
        .in_range     (in_range),
        .first_pos    (first_pos),
        .last_pos     (last_pos)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // zero and oversized lengths fold into the legal range
    function automatic int unsigned effective_window(input logic [LEN_CFG_W-1:0] len_value);
        if (len_value == '0)
            return 1;
        if (len_value > RING_DEPTH)
            return RING_DEPTH;
        return len_value;
    endfunction

    // take one sample into the window copy and work out its result
    function automatic window_result_t predict_window(input logic signed [DATA_W-1:0] s,
                                                      input logic restart);
        window_result_t r;
        int unsigned    len;
        int unsigned    i;
        longint         hi_v;
        longint         lo_v;
        longint         v;
        longint         limit_v;
        if (restart)
        begin
            for (i = 0; i < RING_DEPTH; i++)
                window_ring[i] = '0;
            seen_count = 0;
        end
        ring_head = (ring_head + 1) % RING_DEPTH;
        window_ring[ring_head] = s;
        if (seen_count < POS_TOP)
            seen_count++;
        len = effective_window(len_reg);
        r.full = (seen_count >= len);
        r.ok = 1'b0;
        r.pos_first = POS_FIELD_W'(1);
        if (r.full)
        begin
            hi_v = window_ring[ring_head];
            lo_v = hi_v;
            for (i = 1; i < len; i++)
            begin
                v = window_ring[(ring_head + RING_DEPTH - i) % RING_DEPTH];
                if (v > hi_v)
                    hi_v = v;
                if (v < lo_v)
                    lo_v = v;
            end
            limit_v = {32'd0, limit_reg};
            r.ok = ((hi_v - lo_v) <= limit_v);
            r.pos_first = POS_FIELD_W'(seen_count - len + 1);
        end
        r.pos_last = POS_FIELD_W'(seen_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // result check, request prediction and watchdog, all on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              result_index));
                else
                begin
                    want = pending_results.pop_front();
                    if (window_full !== want.full)
                        report_mismatch($sformatf("result %0d window_full: want %0b got %0b",
                                                  result_index, want.full, window_full));
                    if (in_range !== want.ok)
                        report_mismatch($sformatf("result %0d in_range: want %0b got %0b",
                                                  result_index, want.ok, in_range));
                    if (first_pos !== want.pos_first)
                        report_mismatch($sformatf("result %0d first_pos: want %0d got %0d",
                                                  result_index, want.pos_first, first_pos));
                    if (last_pos !== want.pos_last)
                        report_mismatch($sformatf("result %0d last_pos: want %0d got %0d",
                                                  result_index, want.pos_last, last_pos));
                end
                result_index++;
            end
            if (sample_valid && !sample_stall)
                pending_results.insert(pending_results.size(),
                                       predict_window(sample, first_of_set));
            if ((result_valid && !result_stall) || (sample_valid && !sample_stall)
                || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("tb_sliding_window_range_detector failed");
                $finish;
            end
        end
    end

    // random stall on the result side
    always @(negedge clk)
    begin
        if (!rst_n || quiet_mode)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // send one request, with random gaps in front of it; entered and left at a falling edge
    task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic restart);
        while (!quiet_mode && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        first_of_set <= restart;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    // stop sending and let every pending result come back
    task automatic wait_until_idle();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // one register write, left at a falling edge with valid low
    task automatic write_register(input cfg_index_t idx, input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_WINDOW_LEN)
            len_reg = value[LEN_CFG_W-1:0];
        else
            limit_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // reset values: single sample window, zero limit, field extremes
    task automatic test_reset_defaults();
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(-32'sd1, 1'b0);
    endtask

    // length zero and oversized, full 32-bit spread, not-full windows, length change mid-stream
    task automatic test_window_edges();
        wait_until_idle();
        write_register(CFG_WINDOW_LEN, 32'd0);
        send_sample(32'sh1234_5678, 1'b0);
        send_sample(-32'sd5, 1'b0);
        wait_until_idle();
        write_register(CFG_WINDOW_LEN, 32'd3);
        write_register(CFG_RANGE_LIMIT, 32'hFFFF_FFFF);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        wait_until_idle();
        write_register(CFG_RANGE_LIMIT, 32'hFFFF_FFFE);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        wait_until_idle();
        // shorter window applies over samples already held
        write_register(CFG_WINDOW_LEN, 32'd2);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        wait_until_idle();
        write_register(CFG_RANGE_LIMIT, 32'd0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        wait_until_idle();
        write_register(CFG_WINDOW_LEN, 32'd127);
        send_sample(32'sh0000_0001, 1'b1);
        send_sample(32'sh0000_0001, 1'b0);
    endtask

    // one setting, then bursts of samples in a narrow band with some noise and extremes
    task automatic run_random_phase(input int n_items, input bit calm, input bit pause_mid);
        logic [LEN_CFG_W-1:0]     len_val;
        logic [LIMIT_W-1:0]       limit_val;
        logic [LIMIT_W-1:0]       cfg_word;
        logic [DATA_W-1:0]        base;
        logic [DATA_W-1:0]        spread;
        logic signed [DATA_W-1:0] s;
        logic                     restart;
        int unsigned              eff;
        int unsigned              seg_left;
        int                       k;
        wait_until_idle();
        case ($urandom_range(0, 9))
            0: len_val = LEN_CFG_W'(0);
            1: len_val = LEN_CFG_W'(1);
            2: len_val = LEN_CFG_W'(64);
            3: len_val = LEN_CFG_W'(127);
            4: len_val = LEN_CFG_W'($urandom_range(65, 126));
            5: len_val = LEN_CFG_W'($urandom_range(13, 63));
            default: len_val = LEN_CFG_W'($urandom_range(2, 12));
        endcase
        spread = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 5000);
        case ($urandom_range(0, 7))
            0: limit_val = 0;
            1: limit_val = 32'hFFFF_FFFF;
            2: limit_val = $urandom;
            default: limit_val = spread / 2 + $urandom_range(0, spread);
        endcase
        // upper data bits are ignored by the length register
        cfg_word = {25'd0, len_val};
        if ($urandom_range(0, 3) == 0)
            cfg_word = ($urandom & 32'hFFFF_FF80) | cfg_word;
        write_register(CFG_WINDOW_LEN, cfg_word);
        write_register(CFG_RANGE_LIMIT, limit_val);
        eff = effective_window(len_val);
        quiet_mode = calm;
        seg_left = 0;
        base = $urandom;
        for (k = 0; k < n_items; k++)
        begin
            if (pause_mid && k == n_items / 2)
                wait_until_idle();
            restart = 1'b0;
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(1, 3 * eff + 4);
                base = $urandom;
                restart = ($urandom_range(0, 9) != 0);
            end
            else if ($urandom_range(0, 49) == 0)
                restart = 1'b1;
            seg_left--;
            case ($urandom_range(0, 9))
                0: s = $urandom;
                1:
                begin
                    case ($urandom_range(0, 3))
                        0: s = 32'sh8000_0000;
                        1: s = 32'sh7FFF_FFFF;
                        2: s = 32'sh0000_0000;
                        default: s = -32'sd1;
                    endcase
                end
                default: s = base + $urandom_range(0, spread);
            endcase
            send_sample(s, restart);
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 12; phase++)
            run_random_phase(105, phase == 5, phase == 8);
    endtask

    // short window with no gaps, then the widest window and a restart
    task automatic test_long_window();
        logic [DATA_W-1:0] base;
        int unsigned       i;
        wait_until_idle();
        write_register(CFG_WINDOW_LEN, 32'd4);
        write_register(CFG_RANGE_LIMIT, 32'd8);
        base = $urandom;
        quiet_mode = 1'b1;
        send_sample(base, 1'b1);
        for (i = 1; i < 10; i++)
            send_sample(base + $urandom_range(0, 15), 1'b0);
        quiet_mode = 1'b0;
        wait_until_idle();
        write_register(CFG_WINDOW_LEN, 32'd64);
        write_register(CFG_RANGE_LIMIT, 32'd40);
        for (i = 0; i < 70; i++)
            send_sample(base + $urandom_range(0, 45), 1'b0);
        wait_until_idle();
        write_register(CFG_WINDOW_LEN, 32'd127);
        for (i = 0; i < 3; i++)
            send_sample($urandom, 1'b0);
        send_sample($urandom, 1'b1);
        send_sample($urandom, 1'b0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_WINDOW_LEN;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample       = '0;
        first_of_set = 1'b0;
        result_stall = 1'b0;
        quiet_mode   = 1'b0;
        error_count  = 0;
        result_index = 0;
        stuck_cycles = 0;
        ring_head    = 0;
        seen_count   = 0;
        len_reg      = 1;
        limit_reg    = 0;
        for (int i = 0; i < RING_DEPTH; i++)
            window_ring[i] = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_window_edges();
        test_random_traffic();
        test_long_window();

        wait_until_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("tb_sliding_window_range_detector passed");
        else
            $display("tb_sliding_window_range_detector failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swrd_pkg.sv
rtl/swrd_front.sv
rtl/sliding_window_range_detector.sv
tb/tb_sliding_window_range_detector.sv
